/* sv/b64d_pkg.sv */
// Shared types, codes and widths for the base64 stream decoder.
// Used by the channel interfaces, the decoder modules and the checker.
package b64d_pkg;

  localparam int CAP_W            = 13;
  localparam int LEN_W            = 12;
  localparam int MAX_CAPACITY_DEF = 4096;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd512;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] sextet;
    logic       blank;
  } char_class_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PAD   = 8'h3D;

endpackage

/* sv/b64d_if.sv */
// Valid/ready channel interfaces for the decoder's input and result beats.
// Depends on b64d_pkg for field types.
interface b64d_in_if;
  import b64d_pkg::*;
  logic       valid;
  logic       ready;
  opcode_t    opcode;
  logic [7:0] char_in;

  modport source (output valid, output opcode, output char_in, input ready);
  modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

interface b64d_out_if;
  import b64d_pkg::*;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [7:0]        data_byte;
  logic [LEN_W-1:0]  decoded_length;

  modport source (output valid, output kind, output data_byte, output decoded_length,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input decoded_length,
                  output ready);
endinterface

/* sv/b64d_char_map.sv */
// Classifies one character: base64 sextet value, alphabet membership, blank.
// Depends on b64d_pkg.
module b64d_char_map (
  input  logic [7:0]            ch,
  output b64d_pkg::char_class_t cls
);
  import b64d_pkg::*;

  always_comb begin
    cls.valid  = 1'b1;
    cls.sextet = 6'd0;
    cls.blank  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      cls.sextet = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      cls.sextet = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      cls.sextet = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == CH_PLUS) begin
      cls.sextet = 6'd62;
    end else if (ch == CH_SLASH) begin
      cls.sextet = 6'd63;
    end else begin
      // Anything else, padding included, ends the decode.
      cls.valid = 1'b0;
    end
  end

endmodule

/* sv/b64d_core.sv */
// Decoder state, per-character decode logic and the result register.
// Depends on b64d_pkg and b64d_char_map.
module b64d_core #(
  parameter int MAX_CAPACITY = b64d_pkg::MAX_CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  b64d_pkg::item_t              item,
  input  logic [b64d_pkg::CAP_W-1:0]   capacity,
  output logic                         go,
  b64d_out_if.source                   out_if
);
  import b64d_pkg::*;

  localparam int CAP_MAX_REP = (1 << CAP_W) - 1;
  localparam int CAP_LIM     = (MAX_CAPACITY > CAP_MAX_REP) ? CAP_MAX_REP : MAX_CAPACITY;
  localparam int CNT_W       = (CAP_LIM > 2) ? $clog2(CAP_LIM) : 1;

  logic [1:0]       phase_r, phase_nxt;
  logic [5:0]       held_r, held_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             stopped_r, stopped_nxt;
  logic             failed_r, failed_nxt;

  logic             out_valid_r;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             res_v;

  char_class_t      cls;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] cnt_ext;
  logic [CAP_W:0]   cnt_inc;
  logic [7:0]       dec_byte;
  logic             bad_end;

  b64d_char_map u_char_map (
    .ch  (item.char_in),
    .cls (cls)
  );

  assign go      = item_valid && (!out_valid_r || out_if.ready);
  assign cap     = (capacity < CAP_W'(CAP_LIM)) ? capacity : CAP_W'(CAP_LIM);
  assign cnt_ext = CAP_W'(cnt_r);
  assign cnt_inc = {1'b0, cnt_ext} + 1'b1;
  assign bad_end = failed_r || (phase_r == 2'd1) || (cnt_ext >= cap);

  always_comb begin
    case (phase_r)
      2'd1:    dec_byte = {held_r, cls.sextet[5:4]};
      2'd2:    dec_byte = {held_r[3:0], cls.sextet[5:2]};
      2'd3:    dec_byte = {held_r[1:0], cls.sextet};
      default: dec_byte = 8'd0;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    cnt_nxt     = cnt_r;
    stopped_nxt = stopped_r;
    failed_nxt  = failed_r;
    res_v       = 1'b0;
    kind_nxt    = KIND_DATA;
    byte_nxt    = 8'd0;
    len_nxt     = '0;
    if (go) begin
      if (item.opcode == OP_END) begin
        res_v       = 1'b1;
        kind_nxt    = bad_end ? KIND_ERR : KIND_OK;
        len_nxt     = bad_end ? '0 : cnt_ext[LEN_W-1:0];
        phase_nxt   = 2'd0;
        held_nxt    = 6'd0;
        cnt_nxt     = '0;
        stopped_nxt = 1'b0;
        failed_nxt  = 1'b0;
      end else if (stopped_r || failed_r) begin
        // Decode has ended; characters are dropped until the end beat.
      end else if (phase_r == 2'd0 && cls.blank) begin
        // Blanks between quartets are skipped.
      end else if (!cls.valid) begin
        if (phase_r == 2'd1) begin
          failed_nxt = 1'b1;
        end else begin
          stopped_nxt = 1'b1;
        end
      end else if (phase_r == 2'd0) begin
        held_nxt  = cls.sextet;
        phase_nxt = 2'd1;
      end else if (cnt_ext >= cap) begin
        failed_nxt = 1'b1;
      end else begin
        res_v    = 1'b1;
        byte_nxt = dec_byte;
        // The byte that fills the buffer is still sent, but the length is spent.
        if (cnt_inc >= {1'b0, cap}) begin
          failed_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
        held_nxt  = cls.sextet;
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      held_r      <= 6'd0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      cnt_r     <= cnt_nxt;
      stopped_r <= stopped_nxt;
      failed_r  <= failed_nxt;
      if (go) begin
        out_valid_r <= res_v;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_v) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      len_r  <= len_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = kind_r;
  assign out_if.data_byte      = byte_r;
  assign out_if.decoded_length = len_r;

endmodule

/* sv/base64_stream_decoder.sv */
// Base64 stream decoder: character beats in, data bytes and a final status out.
//
// Input channel in_if: one beat per character (opcode OP_CHAR) or an end beat
// (OP_END). Result channel out_if: a data byte (KIND_DATA) for each completed
// byte, and for every end beat one status beat, KIND_OK with the decoded
// length or KIND_ERR. Characters that complete no byte give no result beat.
// The cfg_we / cfg_wdata port sets the output buffer capacity, terminator
// included; write it only while the block is idle.
// Throughput is one beat per cycle while the receiver is ready: the input
// register feeds one pass of lookup, shift and compare logic that updates the
// decoder state and loads the result register in the same cycle. An accepted
// beat reaches out_if through the input register and then the result register.
// Reset (synchronous, rst_n low) clears the decoder state, empties both
// registers and sets the capacity to 512. When the receiver stalls, the
// result register holds its beat and one more input beat waits in the input
// register; in_if.ready drops only when both are occupied.
// Depends on b64d_pkg, b64d_if and b64d_core.
module base64_stream_decoder #(
  parameter int MAX_CAPACITY = b64d_pkg::MAX_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [b64d_pkg::CAP_W-1:0]  cfg_wdata,
  b64d_in_if.sink                     in_if,
  b64d_out_if.source                  out_if
);
  import b64d_pkg::*;

  logic             in_v_r;
  item_t            item_r;
  logic [CAP_W-1:0] cap_r;
  logic             go;

  assign in_if.ready = !in_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cap_r  <= CAP_RESET;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_v_r <= 1'b1;
      end else if (go) begin
        in_v_r <= 1'b0;
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.opcode  <= in_if.opcode;
      item_r.char_in <= in_if.char_in;
    end
  end

  b64d_core #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_v_r),
    .item       (item_r),
    .capacity   (cap_r),
    .go         (go),
    .out_if     (out_if)
  );

endmodule

/* sv/b64d_checker.sv */
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg for the result kind codes.
module b64d_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [7:0]                  out_data_byte,
  input logic [b64d_pkg::LEN_W-1:0]  out_decoded_length
);
  import b64d_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_decoded_length))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA) || (out_kind == KIND_OK) ||
      (out_kind == KIND_ERR))
    else $error("illegal result kind");

  // Data beats carry no length and status beats carry no byte; errors carry neither.
  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_DATA) && (out_decoded_length == '0)) ||
      ((out_kind == KIND_OK) && (out_data_byte == 8'd0)) ||
      ((out_kind == KIND_ERR) && (out_data_byte == 8'd0) && (out_decoded_length == '0)))
    else $error("result fields inconsistent with kind");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_kind           (out_if.kind),
  .out_data_byte      (out_if.data_byte),
  .out_decoded_length (out_if.decoded_length)
);

/* bench/tb_top.sv */
// Self-checking bench for base64_stream_decoder: directed strings, then random
// well-formed, broken and noise strings across several capacity settings.
// Depends on b64d_pkg, b64d_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import b64d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BEATS = 175;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] decoded_length;
  } result_beat_t;

  // Tracks the decoder state beat by beat and keeps the result beats still owed.
  class decode_scoreboard;
    logic [CAP_W-1:0] capacity;
    logic [1:0]       phase;
    logic [5:0]       held;
    logic [LEN_W-1:0] count;
    bit               stopped;
    bit               failed;
    result_beat_t     expected_beats[$];
    int unsigned      mismatches;

    function new();
      capacity    = CAP_RESET;
      mismatches  = 0;
      clear_decode();
    endfunction

    function void clear_decode();
      phase   = 2'd0;
      held    = 6'd0;
      count   = '0;
      stopped = 1'b0;
      failed  = 1'b0;
    endfunction

    function void accept_item(opcode_t op, logic [7:0] ch);
      int unsigned  cap;
      logic [5:0]   sx;
      bit           in_alphabet;
      logic [7:0]   byte_v;
      result_beat_t r;
      cap = (capacity > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : capacity;
      if (op == OP_END) begin
        r.kind = (failed || phase == 2'd1 || count >= cap) ? KIND_ERR : KIND_OK;
        r.data_byte = 8'd0;
        r.decoded_length = (r.kind == KIND_OK) ? count : '0;
        expected_beats.push_back(r);
        clear_decode();
        return;
      end
      if (stopped || failed) return;
      if (phase == 2'd0 &&
          (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF)) return;

      in_alphabet = 1'b1;
      sx = 6'd0;
      if (ch >= "A" && ch <= "Z") sx = 6'(ch - "A");
      else if (ch >= "a" && ch <= "z") sx = 6'(ch - "a" + 8'd26);
      else if (ch >= "0" && ch <= "9") sx = 6'(ch - "0" + 8'd52);
      else if (ch == CH_PLUS) sx = 6'd62;
      else if (ch == CH_SLASH) sx = 6'd63;
      else in_alphabet = 1'b0;

      if (!in_alphabet) begin
        // A stray character right after the first of a quartet is an error.
        if (phase == 2'd1) failed = 1'b1;
        else stopped = 1'b1;
        return;
      end
      if (phase == 2'd0) begin
        held  = sx;
        phase = 2'd1;
        return;
      end
      case (phase)
        2'd1:    byte_v = {held, sx[5:4]};
        2'd2:    byte_v = {held[3:0], sx[5:2]};
        default: byte_v = {held[1:0], sx};
      endcase
      if (count >= cap) begin
        failed = 1'b1;
        return;
      end
      r.kind = KIND_DATA;
      r.data_byte = byte_v;
      r.decoded_length = '0;
      expected_beats.push_back(r);
      // The byte that fills the buffer is still sent, but the length is then lost.
      if (int'(count) + 1 >= cap) failed = 1'b1;
      else count = count + 1'b1;
      held  = sx;
      phase = phase + 2'd1;
    endfunction

    function void check_result_beat(kind_t k, logic [7:0] d, logic [LEN_W-1:0] n);
      result_beat_t e;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d byte %02h length %0d", k, d, n);
        return;
      end
      e = expected_beats.pop_front();
      if (k !== e.kind || d !== e.data_byte || n !== e.decoded_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected kind %0d byte %02h length %0d,",
                    " got kind %0d byte %02h length %0d"},
                   e.kind, e.data_byte, e.decoded_length, k, d, n);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  decode_scoreboard sb = new();
  logic [7:0]       text_q[$];
  bit               idle_on = 1'b1;
  bit               hold_request = 1'b0;
  logic             long_hold;
  int unsigned      beats_sent = 0;
  int unsigned      cycle_count = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick ready for the next cycle.
  initial begin
    int unsigned stall_left;
    logic        rdy;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result_beat(out_ch.kind, out_ch.data_byte, out_ch.decoded_length);
      if (long_hold) begin
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // One long receiver hold-off so that both internal registers fill up.
  initial begin
    long_hold = 1'b0;
    wait (hold_request);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic send_item(opcode_t op, logic [7:0] ch);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.char_in <= ch;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.accept_item(op, ch);
    beats_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(OP_CHAR, text_q[i]);
    send_item(OP_END, 8'($urandom_range(0, 255)));
    text_q.delete();
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    // A trailing character beat may still be in flight without owing a result.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = value;
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_b64_char();
    int unsigned v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic void build_wellformed();
    int unsigned nq;
    nq = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) text_q.push_back(rand_blank());
      repeat (4) text_q.push_back(rand_b64_char());
    end
    case ($urandom_range(0, 5))
      1: text_q.push_back(rand_b64_char());
      2: begin
        repeat (2) text_q.push_back(rand_b64_char());
        repeat (2) text_q.push_back(CH_PAD);
      end
      3: begin
        repeat (3) text_q.push_back(rand_b64_char());
        text_q.push_back(CH_PAD);
      end
      4: repeat (2) text_q.push_back(rand_b64_char());
      5: repeat (3) text_q.push_back(rand_b64_char());
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) text_q.push_back(rand_blank());
  endfunction

  function automatic void build_broken();
    int unsigned pos;
    build_wellformed();
    if (text_q.size() == 0) text_q.push_back(rand_b64_char());
    pos = $urandom_range(0, text_q.size() - 1);
    text_q[pos] = ($urandom_range(0, 1) == 0) ? rand_blank() : 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 2) == 0) text_q.push_back(rand_b64_char());
      else text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    logic [CAP_W-1:0] cap_list [10];
    int unsigned      pick;
    cap_list = '{13'd0, 13'd1, 13'd3, 13'd8191, 13'd2, 13'd17, 13'd4096, 13'd1, 13'd40,
                 13'd512};
    cap_list[9] = CAP_W'($urandom_range(1, 8191));
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_CHAR;
    in_ch.char_in = 8'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings at the reset capacity.
    push_text("TWFu");
    send_text();
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    push_text("TQ=Q");
    send_text();
    push_text("+ ");
    send_text();
    text_q.push_back(8'h00);
    send_text();
    push_text("/");
    text_q.push_back(8'hFF);
    send_text();
    push_text("9");
    send_text();
    // With room for one byte the second byte fills the buffer.
    write_capacity(13'd2);
    push_text("TWFu");
    send_text();

    beats_sent = 0;
    for (int p = 0; p < 10; p++) begin
      write_capacity(cap_list[p]);
      idle_on = (p < 8);
      if (p == 3) hold_request = 1'b1;
      while (beats_sent < (p + 1) * PHASE_BEATS) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) build_wellformed();
        else if (pick < 17) build_broken();
        else build_noise();
        send_text();
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
